@@ rtl/acl_fc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acl_fc_pkg;

  localparam int unsigned AddrWidth = 4;

  localparam logic [1:0] REG_DIRECTION    = 2'd0;
  localparam logic [1:0] REG_SIZE_ONLY    = 2'd1;
  localparam logic [1:0] REG_OUT_CAPACITY = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_OVER    = 2'd2;

  localparam logic [31:0] XATTR_VER = 32'd2;
  localparam logic [31:0] DISK_VER  = 32'd1;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  localparam logic [15:0] TAG_USER_OBJ  = 16'h0001;
  localparam logic [15:0] TAG_USER      = 16'h0002;
  localparam logic [15:0] TAG_GROUP_OBJ = 16'h0004;
  localparam logic [15:0] TAG_GROUP     = 16'h0008;
  localparam logic [15:0] TAG_MASK      = 16'h0010;
  localparam logic [15:0] TAG_OTHER     = 16'h0020;

  typedef struct packed {
    logic [31:0] data_word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        is_status;
    logic [1:0]  status_code;
    logic [15:0] needed_bytes;
    logic        last;
  } out_item_t;

  function automatic logic tag_is_short(input logic [15:0] tag);
    return (tag == TAG_USER_OBJ) || (tag == TAG_GROUP_OBJ) ||
           (tag == TAG_MASK) || (tag == TAG_OTHER);
  endfunction

  function automatic logic tag_has_id(input logic [15:0] tag);
    return (tag == TAG_USER) || (tag == TAG_GROUP);
  endfunction

endpackage

`default_nettype wire

@@ rtl/acl_fc_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface acl_fc_stream_if #(
  parameter type payload_t = logic [31:0]
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ rtl/acl_format_converter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// The results of an accepted word are registered into the queue, whose head drives the output.
// Results leave a four-entry queue one a cycle while the output is ready; a short
// disk entry yields two results, and the last word of a blob adds a status result.
// A new word is taken whenever at most one result is still queued.
// Reset is asynchronous and active low; it empties the queue, restarts the
// conversion at the header word and sets the registers to their defaults.
module acl_format_converter #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [acl_fc_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  acl_fc_stream_if.sink                          in_i,
  acl_fc_stream_if.source                        out_o
);

  import acl_fc_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_ENTRY  = 2'd1;
  localparam logic [1:0] PH_ID     = 2'd2;

  localparam int unsigned Depth = 4;
  localparam int unsigned WideBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic                  direction_q;
  logic                  size_only_q;
  logic [15:0]           capacity_q;

  logic [1:0]            phase_q, phase_d;
  logic                  full_q, full_d;
  logic                  err_q, err_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  out_item_t             queue_q [Depth];
  out_item_t             queue_d [Depth];
  logic [2:0]            fill_q, fill_d;

  logic                  cfg_write;
  logic                  accept;
  logic                  pop;

  logic [31:0]           word;
  logic [15:0]           tag;
  logic                  is_short;
  logic [31:0]           data0, data1;
  logic [1:0]            data_n;
  logic [3:0]            add_bytes;
  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS:0]   count_sum;
  logic [COUNT_BITS-1:0] count_next;
  logic [WideBits-1:0]   count_wide;
  logic                  err_next;
  logic [1:0]            phase_next;
  logic                  full_next;
  out_item_t             status;
  out_item_t             push_item [3];
  logic [1:0]            push_n;
  logic [2:0]            base;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_DIRECTION: begin
        prdata = {31'd0, direction_q};
      end
      REG_SIZE_ONLY: begin
        prdata = {31'd0, size_only_q};
      end
      REG_OUT_CAPACITY: begin
        prdata = {16'd0, capacity_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
      size_only_q <= 1'b0;
      capacity_q  <= 16'hFFFF;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_DIRECTION: begin
          direction_q <= pwdata[0];
        end
        REG_SIZE_ONLY: begin
          size_only_q <= pwdata[0];
        end
        REG_OUT_CAPACITY: begin
          capacity_q <= pwdata[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready    = (fill_q <= 3'd1);
  assign accept        = in_i.valid && in_i.ready;
  assign out_o.valid   = (fill_q != 3'd0);
  assign out_o.payload = queue_q[0];
  assign pop           = out_o.valid && out_o.ready;

  assign word     = in_i.payload.data_word;
  assign tag      = word[15:0];
  assign is_short = tag_is_short(tag);

  always_comb begin
    data0      = word;
    data1      = ALL_ONES;
    data_n     = 2'd0;
    add_bytes  = 4'd0;
    count_base = count_q;
    err_next   = err_q;
    phase_next = phase_q;
    full_next  = full_q;
    case (phase_q)
      PH_ENTRY: begin
        data_n    = 2'd1;
        if (!direction_q) begin
          add_bytes  = is_short ? 4'd4 : 4'd8;
          full_next  = !is_short;
          phase_next = PH_ID;
        end else begin
          add_bytes = 4'd8;
          if (tag_has_id(tag)) begin
            full_next  = 1'b1;
            phase_next = PH_ID;
          end else begin
            if (!is_short) begin
              err_next = 1'b1;
            end
            data_n = 2'd2;
          end
        end
      end
      PH_ID: begin
        data_n     = (direction_q || full_q) ? 2'd1 : 2'd0;
        phase_next = PH_ENTRY;
      end
      default: begin
        if (word != (direction_q ? DISK_VER : XATTR_VER)) begin
          err_next = 1'b1;
        end
        data0      = direction_q ? XATTR_VER : DISK_VER;
        data_n     = 2'd1;
        count_base = '0;
        add_bytes  = 4'd4;
        phase_next = PH_ENTRY;
      end
    endcase
    if (size_only_q) begin
      data_n = 2'd0;
    end
  end

  assign count_sum  = {1'b0, count_base} + (COUNT_BITS + 1)'(add_bytes);
  assign count_next = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
  assign count_wide = WideBits'(count_next);

  always_comb begin
    status              = '0;
    status.is_status    = 1'b1;
    status.last         = 1'b1;
    status.needed_bytes = (count_wide > WideBits'(16'hFFFF)) ? 16'hFFFF : count_wide[15:0];
    if (err_next || (phase_next == PH_ID)) begin
      status.status_code = STATUS_INVALID;
    end else if (!size_only_q &&
                 ((&count_next) || (count_wide > WideBits'(capacity_q)))) begin
      status.status_code = STATUS_OVER;
    end else begin
      status.status_code = STATUS_OK;
    end
  end

  always_comb begin
    push_item[0]          = '0;
    push_item[1]          = '0;
    push_item[2]          = '0;
    push_item[0].out_word = data0;
    push_item[1].out_word = data1;
    push_n                = data_n;
    if (in_i.payload.last_word) begin
      push_item[data_n] = status;
      push_n            = data_n + 2'd1;
    end
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  assign base = fill_q - {2'd0, pop};

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && (i < Depth - 1)) begin
        queue_d[i] = queue_q[i + 1];
      end else begin
        queue_d[i] = queue_q[i];
      end
      for (int k = 0; k < 3; k++) begin
        if ((2'(k) < push_n) && (3'(i) == base + 3'(k))) begin
          queue_d[i] = push_item[k];
        end
      end
    end
    fill_d = base + {1'b0, push_n};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

  always_comb begin
    phase_d = phase_q;
    full_d  = full_q;
    err_d   = err_q;
    count_d = count_q;
    if (accept) begin
      if (in_i.payload.last_word) begin
        phase_d = PH_HEADER;
        full_d  = 1'b0;
        err_d   = 1'b0;
        count_d = '0;
      end else begin
        phase_d = phase_next;
        full_d  = full_next;
        err_d   = err_next;
        count_d = count_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 3'd0;
      phase_q <= PH_HEADER;
      full_q  <= 1'b0;
      err_q   <= 1'b0;
      count_q <= '0;
    end else begin
      fill_q  <= fill_d;
      phase_q <= phase_d;
      full_q  <= full_d;
      err_q   <= err_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ dv/acl_format_converter_test.sv @@
`timescale 1ns / 1ps

module acl_format_converter_test;
  import acl_fc_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CountMax = 65535;

  typedef enum logic [1:0] {PH_HEADER, PH_ENTRY, PH_ID} conv_phase_e;
  typedef enum logic [1:0] {KIND_SHORT, KIND_NAMED, KIND_UNKNOWN} tag_kind_e;
  typedef logic [31:0] word_q_t[$];

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  acl_fc_stream_if #(.payload_t(in_item_t))  in_if ();
  acl_fc_stream_if #(.payload_t(out_item_t)) out_if ();

  acl_format_converter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  logic        cfg_direction;
  logic        cfg_size_only;
  logic [15:0] cfg_capacity;

  conv_phase_e conv_phase;
  logic        conv_entry_full;
  logic        conv_error;
  int unsigned conv_bytes;

  out_item_t   results_due[$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned blobs_sent;
  int unsigned results_checked;
  int unsigned burst_left;
  int unsigned cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Cycle limit reached with %0d results outstanding", results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic tag_kind_e classify_tag(input logic [15:0] tag);
    case (tag)
      TAG_USER_OBJ, TAG_GROUP_OBJ, TAG_MASK, TAG_OTHER: return KIND_SHORT;
      TAG_USER, TAG_GROUP: return KIND_NAMED;
      default: return KIND_UNKNOWN;
    endcase
  endfunction

  function automatic void count_bytes(input int unsigned n);
    conv_bytes = (conv_bytes + n > CountMax) ? CountMax : conv_bytes + n;
  endfunction

  function automatic void expect_word(input logic [31:0] w);
    if (!cfg_size_only) begin
      results_due.push_back(out_item_t'{out_word: w, is_status: 1'b0,
                                        status_code: STATUS_OK, needed_bytes: 16'd0,
                                        last: 1'b0});
    end
  endfunction

  function automatic void convert_word(input logic [31:0] w, input logic last_word);
    tag_kind_e   kind;
    logic [1:0]  code;
    kind = classify_tag(w[15:0]);
    case (conv_phase)
      PH_ENTRY: begin
        if (!cfg_direction) begin
          expect_word(w);
          count_bytes(kind == KIND_SHORT ? 4 : 8);
          conv_entry_full = (kind != KIND_SHORT);
          conv_phase = PH_ID;
        end else begin
          count_bytes(8);
          expect_word(w);
          if (kind == KIND_NAMED) begin
            conv_entry_full = 1'b1;
            conv_phase = PH_ID;
          end else begin
            if (kind == KIND_UNKNOWN) conv_error = 1'b1;
            expect_word(ALL_ONES);
          end
        end
      end
      PH_ID: begin
        if (cfg_direction || conv_entry_full) expect_word(w);
        conv_phase = PH_ENTRY;
      end
      default: begin
        if (w != (cfg_direction ? DISK_VER : XATTR_VER)) conv_error = 1'b1;
        expect_word(cfg_direction ? XATTR_VER : DISK_VER);
        conv_bytes = 4;
        conv_phase = PH_ENTRY;
      end
    endcase
    if (last_word) begin
      if (conv_phase == PH_ID) conv_error = 1'b1;
      if (conv_error) begin
        code = STATUS_INVALID;
      end else if (!cfg_size_only && (conv_bytes == CountMax || conv_bytes > cfg_capacity)) begin
        code = STATUS_OVER;
      end else begin
        code = STATUS_OK;
      end
      results_due.push_back(out_item_t'{out_word: 32'd0, is_status: 1'b1, status_code: code,
                                        needed_bytes: 16'(conv_bytes), last: 1'b1});
      conv_phase = PH_HEADER;
      conv_entry_full = 1'b0;
      conv_error = 1'b0;
      conv_bytes = 0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    out_item_t got;
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result 0x%0h arrived with none expected", $time, got);
      end else begin
        want = results_due.pop_front();
        results_checked++;
        check_field("out_word", want.out_word, got.out_word);
        check_field("is_status", 32'(want.is_status), 32'(got.is_status));
        check_field("status_code", 32'(want.status_code), 32'(got.status_code));
        check_field("needed_bytes", 32'(want.needed_bytes), 32'(got.needed_bytes));
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  initial begin : receiver
    int unsigned stall_left;
    int unsigned mode;
    int unsigned mode_left;
    out_if.ready = 1'b0;
    stall_left = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if ((mode == 1 && $urandom_range(0, 7) == 0) ||
                   (mode == 2 && $urandom_range(0, 2) == 0)) begin
        out_if.ready <= 1'b0;
        stall_left = (mode == 1) ? $urandom_range(0, 2) : $urandom_range(0, 9);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Each request is run through the predictor at the clock edge that accepts it.
  task automatic send_word(input logic [31:0] w, input logic last_word);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.payload <= in_item_t'{data_word: w, last_word: last_word};
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    if (last_word) blobs_sent++;
    convert_word(w, last_word);
    @(negedge clk_i);
  endtask

  task automatic send_blob(input word_q_t words);
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] field_mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DIRECTION: cfg_direction = value[0];
      REG_SIZE_ONLY: cfg_size_only = value[0];
      REG_OUT_CAPACITY: cfg_capacity = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    field_mask = (idx == REG_OUT_CAPACITY) ? 32'h0000_FFFF : 32'h0000_0001;
    check_field("register readback", value & field_mask, readback & field_mask);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic dir, input logic size_only, input logic [15:0] cap);
    write_reg(REG_DIRECTION, {31'd0, dir});
    write_reg(REG_SIZE_ONLY, {31'd0, size_only});
    write_reg(REG_OUT_CAPACITY, {16'd0, cap});
  endtask

  function automatic logic [31:0] entry(input logic [15:0] tag, input logic [15:0] perm);
    return {perm, tag};
  endfunction

  function automatic logic [15:0] random_known_tag();
    case ($urandom_range(0, 5))
      0: return TAG_USER_OBJ;
      1: return TAG_USER;
      2: return TAG_GROUP_OBJ;
      3: return TAG_GROUP;
      4: return TAG_MASK;
      default: return TAG_OTHER;
    endcase
  endfunction

  function automatic void build_random_blob(output word_q_t words);
    int unsigned flavour;
    int unsigned n;
    logic [15:0] tag;
    flavour = $urandom_range(0, 9);
    words.delete();
    if (flavour == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) words.push_back($urandom);
    end else begin
      if (flavour == 1 && $urandom_range(0, 2) == 0) words.push_back($urandom);
      else words.push_back(cfg_direction ? DISK_VER : XATTR_VER);
      n = $urandom_range(0, 8);
      repeat (n) begin
        tag = random_known_tag();
        if (flavour == 1 && $urandom_range(0, 3) == 0) tag = 16'($urandom_range(0, 65535));
        words.push_back(entry(tag, 16'($urandom_range(0, 65535))));
        if (!cfg_direction || classify_tag(tag) == KIND_NAMED) begin
          if (!cfg_direction && classify_tag(tag) == KIND_SHORT && $urandom_range(0, 1))
            words.push_back(ALL_ONES);
          else
            words.push_back($urandom);
        end
      end
      if (flavour == 1 && $urandom_range(0, 1)) begin
        words.push_back(entry(TAG_USER, 16'($urandom_range(0, 65535))));
      end
    end
  endfunction

  task automatic test_xattr_to_disk();
    set_config(1'b0, 1'b0, 16'hFFFF);
    send_blob('{XATTR_VER, entry(TAG_USER_OBJ, 16'h0007), ALL_ONES,
                entry(TAG_USER, 16'h0006), 32'd1000,
                entry(TAG_GROUP_OBJ, 16'h0005), ALL_ONES,
                entry(TAG_GROUP, 16'hFFFF), 32'hFFFF_FFFE,
                entry(TAG_MASK, 16'h0000), ALL_ONES,
                entry(TAG_OTHER, 16'h0004), 32'h0000_0000});
    wait_idle();
  endtask

  task automatic test_disk_to_xattr();
    set_config(1'b1, 1'b0, 16'hFFFF);
    send_blob('{DISK_VER, entry(TAG_USER_OBJ, 16'h0007), entry(TAG_USER, 16'h0006), 32'd0,
                entry(TAG_GROUP_OBJ, 16'h0005), entry(TAG_GROUP, 16'h0004), ALL_ONES,
                entry(TAG_MASK, 16'h0007), entry(TAG_OTHER, 16'h0000)});
    wait_idle();
  endtask

  task automatic test_malformed_blobs();
    set_config(1'b1, 1'b0, 16'hFFFF);
    send_blob('{32'h0000_0000, entry(TAG_OTHER, 16'h0000)});
    send_blob('{DISK_VER, entry(16'h0000, 16'hFFFF), entry(16'hFFFF, 16'h1234)});
    send_blob('{DISK_VER, entry(TAG_GROUP, 16'h0006)});
    send_blob('{DISK_VER});
    wait_idle();
    set_config(1'b0, 1'b0, 16'hFFFF);
    send_blob('{32'hFFFF_FFFF});
    send_blob('{XATTR_VER, entry(16'h0003, 16'h0007), 32'd55});
    send_blob('{XATTR_VER, entry(TAG_MASK, 16'h0007)});
    wait_idle();
  endtask

  task automatic test_capacity_limits();
    logic [15:0] caps [4];
    caps = '{16'd0, 16'd19, 16'd20, 16'hFFFF};
    foreach (caps[i]) begin
      set_config(1'b0, 1'b0, caps[i]);
      send_blob('{XATTR_VER, entry(TAG_USER_OBJ, 16'h0006), ALL_ONES,
                  entry(TAG_USER, 16'h0004), 32'd42, entry(TAG_OTHER, 16'h0001), ALL_ONES});
      wait_idle();
    end
    set_config(1'b0, 1'b0, 16'd0);
    send_blob('{32'd7, entry(TAG_MASK, 16'h0007), ALL_ONES});
    wait_idle();
    set_config(1'b0, 1'b1, 16'd0);
    send_blob('{XATTR_VER, entry(TAG_GROUP, 16'h0005), 32'd9, entry(TAG_OTHER, 16'h0000), 32'd0});
    wait_idle();
  endtask

  task automatic test_direction_switch();
    set_config(1'b0, 1'b0, 16'hFFFF);
    send_word(XATTR_VER, 1'b0);
    send_word(entry(TAG_USER, 16'h0006), 1'b0);
    wait_idle();
    write_reg(REG_DIRECTION, 32'd1);
    send_word(32'd77, 1'b0);
    send_word(entry(TAG_MASK, 16'h0007), 1'b0);
    wait_idle();
    write_reg(REG_DIRECTION, 32'd0);
    send_word(entry(TAG_OTHER, 16'h0004), 1'b0);
    send_word(ALL_ONES, 1'b1);
    wait_idle();
  endtask

  task automatic test_long_blobs();
    logic [15:0] tag;
    for (int so = 1; so >= 0; so--) begin
      set_config(1'b1, so[0], 16'd60);
      send_word(DISK_VER, 1'b0);
      for (int i = 0; i < 12; i++) begin
        case ($urandom_range(0, 3))
          0: tag = TAG_USER_OBJ;
          1: tag = TAG_GROUP_OBJ;
          2: tag = TAG_MASK;
          default: tag = TAG_OTHER;
        endcase
        send_word(entry(tag, 16'($urandom_range(0, 65535))), i == 11);
      end
      wait_idle();
    end
  endtask

  task automatic test_random_blobs();
    int unsigned start;
    logic [15:0] cap;
    word_q_t     words;
    start = words_sent;
    while (words_sent - start < 50) begin
      if ($urandom_range(0, 1)) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: cap = 16'd0;
          1: cap = 16'hFFFF;
          2: cap = 16'($urandom_range(0, 120));
          default: cap = 16'($urandom_range(0, 65535));
        endcase
        set_config(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, cap);
      end
      build_random_blob(words);
      send_blob(words);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_direction = 1'b0;
    cfg_size_only = 1'b0;
    cfg_capacity = 16'hFFFF;
    conv_phase = PH_HEADER;
    conv_entry_full = 1'b0;
    conv_error = 1'b0;
    conv_bytes = 0;
    mismatches = 0;
    words_sent = 0;
    blobs_sent = 0;
    results_checked = 0;
    burst_left = 0;
    cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_xattr_to_disk();
    test_disk_to_xattr();
    test_malformed_blobs();
    test_capacity_limits();
    test_direction_switch();
    test_long_blobs();
    test_random_blobs();

    while (results_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Converted %0d blobs from %0d words in both directions, %0d results checked.",
             blobs_sent, words_sent, results_checked);
    $display("Runs covered size-only mode, capacity limits, malformed blobs and long blobs.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
